/* sv/asid_allocator_assert.svh */
// ----------------------------------------------------------------------------
// ASID allocator assertion macros
// Shared property forms for the allocator's port checker.
// ----------------------------------------------------------------------------
`ifndef ASID_ALLOCATOR_ASSERT_SVH
`define ASID_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define AA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("asid_allocator: port check failed");

// Next-cycle implication, masked while reset is asserted.
`define AA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("asid_allocator: port check failed");

// Next-cycle implication that is also checked across reset.
`define AA_ASSERT_NEXT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("asid_allocator: reset check failed");

`endif

/* sv/asid_alloc_pkg.sv */
// ----------------------------------------------------------------------------
// ASID allocator package
// Field widths, action codes, reset values and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package asid_alloc_pkg;

    // Fixed field widths of the stream beats and the used count.
    localparam int ASID_W   = 8;
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 9;

    // Default bitmap size and register reset values.
    localparam int                ASID_BITS_DEF  = 8;
    localparam logic [ASID_W-1:0] MAX_ASID_RESET = 8'd255;
    localparam logic [ASID_W-1:0] NEXT_RESET     = 8'd1;

    // Action codes carried on s_tuser.
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;    // latch the input beat
        logic init_scan;  // load the scan start point and clear the probe count
        logic step;       // advance the scan candidate with wrap
        logic rd_en;      // read the used mark at the current ASID
        logic clr_wr;     // clearing sweep write
        logic mark_set;   // set the used mark at the current ASID
        logic mark_clr;   // clear the used mark at the current ASID
        logic cnt_inc;
        logic cnt_dec;
        logic next_load;  // move the next-candidate pointer to the current ASID
        logic push_ok;    // load a successful result beat
        logic push_fail;  // load a failed result beat
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // clearing sweep is at its last entry
        logic act_alloc;
        logic act_release;
        logic act_reserve;
        logic pre_fail;    // request fails without looking at the bitmap
        logic mark;        // used mark read back for the current ASID
        logic last_iter;   // current probe is the last one the scan allows
        logic out_free;    // output register can take a beat this cycle
    } dp_status_t;

endpackage

/* sv/asid_allocator.sv */
// Sequencing: S_START answers a request refused before the bitmap is read; release and
// reserve read one mark in S_PROBE (the RAM read port is registered) and test it in
// S_TEST; an allocate repeats both states for each ASID it probes. One request at a time;
// the next beat is taken while a result waits in the output reg. Reset: synchronous; a
// clearing sweep of all 2**ASID_BITS entries (256 by default) follows, during which
// s_tready stays low. Configuration writes are taken whenever reset is not asserted.
// ----------------------------------------------------------------------------
// ASID allocator
// Round-robin address-space identifier allocator with release and reserve.
// ----------------------------------------------------------------------------
module asid_allocator #(
    parameter int ASID_BITS = asid_alloc_pkg::ASID_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [asid_alloc_pkg::ASID_W-1:0]   s_tdata,   // [7:0] asid_in
    input  logic [asid_alloc_pkg::ACTION_W-1:0] s_tuser,   // [1:0] action
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [asid_alloc_pkg::ASID_W-1:0]   m_tdata,   // [7:0] asid_out
    output logic [0:0]                          m_tuser,   // [0] ok
    // max_asid register write
    input  logic                                cfg_wr_en,
    input  logic [asid_alloc_pkg::ASID_W-1:0]   cfg_wr_data
);

    asid_alloc_pkg::ctrl_cmd_t  cmd;
    asid_alloc_pkg::dp_status_t status;
    logic                       out_ok;

    asid_alloc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asid_alloc_dp #(
        .ASID_BITS (ASID_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_action   (s_tuser),
        .in_asid     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_asid    (m_tdata),
        .out_ok      (out_ok)
    );

    assign m_tuser = out_ok;

endmodule

/* sv/asid_alloc_ram.sv */
// ----------------------------------------------------------------------------
// ASID allocator RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module asid_alloc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds when not read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/asid_alloc_dp.sv */
// ----------------------------------------------------------------------------
// ASID allocator datapath
// Used-mark bitmap, used count, next-candidate pointer, scan candidate and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module asid_alloc_dp #(
    parameter int ASID_BITS = asid_alloc_pkg::ASID_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input beat fields
    input  logic [asid_alloc_pkg::ACTION_W-1:0]   in_action,
    input  logic [asid_alloc_pkg::ASID_W-1:0]     in_asid,
    // Configuration write
    input  logic                                  cfg_wr_en,
    input  logic [asid_alloc_pkg::ASID_W-1:0]     cfg_wr_data,
    // Controller interface
    input  asid_alloc_pkg::ctrl_cmd_t             cmd,
    output asid_alloc_pkg::dp_status_t            status,
    // Result channel
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [asid_alloc_pkg::ASID_W-1:0]     out_asid,
    output logic                                  out_ok
);

    localparam int ASID_W  = asid_alloc_pkg::ASID_W;
    localparam int COUNT_W = asid_alloc_pkg::COUNT_W;
    localparam int DEPTH   = 1 << ASID_BITS;
    // Largest ASID the bitmap can hold, seen through the 8-bit field.
    localparam int LIM_CAP = (ASID_BITS >= ASID_W) ? ((1 << ASID_W) - 1) : (DEPTH - 1);
    localparam logic [ASID_W-1:0] LIM_CAP_V = ASID_W'(LIM_CAP);

    logic [ASID_W-1:0]         max_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [ASID_W-1:0]         next_reg;
    logic [ASID_W-1:0]         cur_reg;
    logic [ASID_W-1:0]         iter_reg;
    logic [asid_alloc_pkg::ACTION_W-1:0] action_reg;
    logic [ASID_BITS-1:0]      clr_addr_reg;
    logic                      m_valid_reg;
    logic [ASID_W-1:0]         m_asid_reg;
    logic                      m_ok_reg;

    logic [ASID_W-1:0]           lim;
    logic [ASID_W-1:0]           scan_start;
    logic [ASID_W:0]             cur_inc;
    logic [ASID_W-1:0]           cur_step;
    logic [ASID_W+ASID_BITS-1:0] cur_ext;
    logic [ASID_BITS-1:0]        cur_addr;
    logic                        in_range;
    logic                        ram_wr_en;
    logic [ASID_BITS-1:0]        ram_wr_addr;
    logic                        ram_rd_data;

    // Allocation limit and the point where a scan begins.
    assign lim        = (max_reg > LIM_CAP_V) ? LIM_CAP_V : max_reg;
    assign scan_start = (next_reg == '0 || next_reg > lim) ? ASID_W'(1) : next_reg;

    // Next candidate, wrapping past the limit back to one.
    assign cur_inc  = {1'b0, cur_reg} + (ASID_W + 1)'(1);
    assign cur_step = (cur_inc > {1'b0, lim}) ? ASID_W'(1) : cur_inc[ASID_W-1:0];

    // Bitmap address of the current ASID and its range check.
    assign cur_ext  = {{ASID_BITS{1'b0}}, cur_reg};
    assign cur_addr = cur_ext[ASID_BITS-1:0];
    assign in_range = (cur_ext[ASID_W+ASID_BITS-1:ASID_BITS] == '0);

    // Bitmap write port: clearing sweep or a mark update.
    assign ram_wr_en   = cmd.clr_wr | cmd.mark_set | cmd.mark_clr;
    assign ram_wr_addr = cmd.clr_wr ? clr_addr_reg : cur_addr;

    asid_alloc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_mark_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cmd.mark_set),
        .rd_en   (cmd.rd_en),
        .rd_addr (cur_addr),
        .rd_data (ram_rd_data)
    );

    // Status decode for the controller.
    always_comb begin
        status             = '0;
        status.clear_last  = (clr_addr_reg == '1);
        status.mark        = ram_rd_data;
        status.last_iter   = (iter_reg == lim - ASID_W'(1));
        status.out_free    = !m_valid_reg || m_tready;
        case (action_reg)
            asid_alloc_pkg::ACT_ALLOC: begin
                status.act_alloc = 1'b1;
                status.pre_fail  = (count_reg > {1'b0, max_reg}) || (lim == '0);
            end
            asid_alloc_pkg::ACT_RELEASE: begin
                status.act_release = 1'b1;
                status.pre_fail    = !in_range;
            end
            asid_alloc_pkg::ACT_RESERVE: begin
                status.act_reserve = 1'b1;
                status.pre_fail    = !in_range;
            end
            default: begin
                status.pre_fail = 1'b1;
            end
        endcase
    end

    // Control registers: limit, count, pointer, sweep address, result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg      <= asid_alloc_pkg::MAX_ASID_RESET;
            count_reg    <= '0;
            next_reg     <= asid_alloc_pkg::NEXT_RESET;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + COUNT_W'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - COUNT_W'(1);
            end
            if (cmd.next_load) begin
                next_reg <= cur_reg;
            end
            if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + ASID_BITS'(1);
            end
            if (cmd.push_ok || cmd.push_fail) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request, scan position and result fields.
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            action_reg <= in_action;
            cur_reg    <= in_asid;
        end else if (cmd.init_scan) begin
            cur_reg <= scan_start;
        end else if (cmd.step) begin
            cur_reg <= cur_step;
        end
        if (cmd.init_scan) begin
            iter_reg <= '0;
        end else if (cmd.step) begin
            iter_reg <= iter_reg + ASID_W'(1);
        end
        if (cmd.push_ok) begin
            m_asid_reg <= cur_reg;
            m_ok_reg   <= 1'b1;
        end else if (cmd.push_fail) begin
            m_asid_reg <= '0;
            m_ok_reg   <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign out_asid = m_asid_reg;
    assign out_ok   = m_ok_reg;

endmodule

/* sv/asid_alloc_ctrl.sv */
// ----------------------------------------------------------------------------
// ASID allocator controller
// Sequences the clearing sweep after reset and the bitmap probes of each
// request, and decides when a result beat is loaded.
// ----------------------------------------------------------------------------
module asid_alloc_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  asid_alloc_pkg::dp_status_t status,
    output asid_alloc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_PROBE,
        S_TEST
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic hit;
    logic miss;

    // A probe succeeds on a free ASID for allocate and reserve, a used one
    // for release. Only an allocate scan goes on past a used ASID, until its last probe.
    always_comb begin
        hit  = 1'b0;
        miss = 1'b0;
        if (status.act_alloc) begin
            hit  = !status.mark;
            miss = status.mark && status.last_iter;
        end else if (status.act_release) begin
            hit  = status.mark;
            miss = !status.mark;
        end else if (status.act_reserve) begin
            hit  = !status.mark;
            miss = status.mark;
        end
    end

    // Next state and commands.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                if (status.pre_fail) begin
                    if (status.out_free) begin
                        cmd.push_fail = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    cmd.init_scan = status.act_alloc;
                    state_next    = S_PROBE;
                end
            end
            S_PROBE: begin
                cmd.rd_en  = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (hit) begin
                    if (status.out_free) begin
                        cmd.push_ok   = 1'b1;
                        cmd.mark_set  = !status.act_release;
                        cmd.mark_clr  = status.act_release;
                        cmd.cnt_inc   = !status.act_release;
                        cmd.cnt_dec   = status.act_release;
                        cmd.next_load = status.act_alloc || status.act_release;
                        state_next    = S_IDLE;
                    end
                end else if (miss) begin
                    if (status.out_free) begin
                        cmd.push_fail = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

/* sv/asid_alloc_checker.sv */
// ----------------------------------------------------------------------------
// ASID allocator port checker
// Watches the allocator's ports over time; bound to every allocator instance.
// ----------------------------------------------------------------------------
`include "asid_allocator_assert.svh"

module asid_alloc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [asid_alloc_pkg::ASID_W-1:0] m_tdata,
    input logic [0:0]                        m_tuser
);

    // A stalled result beat keeps its contents.
    `AA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

    // A failed request always reports ASID zero.
    `AA_ASSERT_NOW(a_fail_zero, m_tvalid && !m_tuser[0], m_tdata == '0)

    // Requests are handled one at a time.
    `AA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

    // Reset starts the clearing sweep with no result pending.
    `AA_ASSERT_NEXT_RST(a_reset_quiet, !aresetn, !s_tready && !m_tvalid)

endmodule

bind asid_allocator asid_alloc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
